// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top level of the log repeat suppression table.
// Each macro expects a clock named aclk and an active-low reset named aresetn.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property checked at every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// A condition that must never be true outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    `ASSERT_CLK(label, !(cond), msg)

`endif

// ===== rtl/lrst_pkg.sv =====
// Shared types and constants for the log repeat suppression table.
// Used by lrst_cell and log_repeat_suppression_table; depends on nothing else.
package lrst_pkg;

    localparam int SLOTS_DEF  = 8;
    localparam int SIG_W      = 32;
    localparam int PRI_W      = 8;
    localparam int CNT_W      = 16;
    localparam int TIME_W     = 64;
    localparam int SLOT_W     = 3;
    localparam int ACT_W      = 2;
    localparam int LVL_W      = 3;
    localparam int DEDUP_W    = 8;
    localparam int US_W       = 20;
    localparam int WIN_W      = DEDUP_W + US_W;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 8;
    localparam int IN_DATA_W  = 104;
    localparam int OUT_DATA_W = 128;

    localparam logic [US_W-1:0] US_PER_SECOND = 20'd1000000;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_CONSOLE = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_HOST    = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_DEDUP   = 2'd2;

    typedef enum logic [ACT_W-1:0] {
        ACT_DROP    = 2'd0,
        ACT_SUPP    = 2'd1,
        ACT_REPORT  = 2'd2,
        ACT_DISPLAY = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DROP,
        ST_SEARCH,
        ST_SUPP,
        ST_REPORT,
        ST_DISP
    } state_t;

    // Search token handed from cell to cell. It carries the chosen slot's
    // contents: the matching slot once found, otherwise the eviction choice.
    typedef struct packed {
        logic              valid;
        logic              found;
        logic              have;
        logic [CNT_W-1:0]  cnt;
        logic [TIME_W-1:0] seen;
        logic [TIME_W-1:0] anchor;
        logic [SIG_W-1:0]  sig;
        logic [PRI_W-1:0]  pri;
    } scan_t;

    // Write-back command broadcast to all cells.
    typedef struct packed {
        logic              en;
        logic              set_anchor;
        logic [SIG_W-1:0]  sig;
        logic [PRI_W-1:0]  pri;
        logic [CNT_W-1:0]  cnt;
        logic [TIME_W-1:0] seen;
    } slot_wr_t;

endpackage

// ===== rtl/lrst_cell.sv =====
// One table slot of the log repeat suppression table and its search stage.
// Depends on lrst_pkg for the token and write-back types.
module lrst_cell #(
    parameter int IDX_W    = 3,
    parameter int CELL_IDX = 0
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic [lrst_pkg::SIG_W-1:0] req_sig,
    input  logic [lrst_pkg::PRI_W-1:0] req_pri,
    input  lrst_pkg::scan_t          tok_in,
    input  logic [IDX_W-1:0]         idx_in,
    output lrst_pkg::scan_t          tok_out,
    output logic [IDX_W-1:0]         idx_out,
    input  lrst_pkg::slot_wr_t       wr,
    input  logic [IDX_W-1:0]         wr_idx
);
    import lrst_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic [SIG_W-1:0]  sig_reg;
    logic [PRI_W-1:0]  pri_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [TIME_W-1:0] seen_reg;
    logic [TIME_W-1:0] anchor_reg;

    scan_t             tok_reg, tok_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              own_match;
    logic              take_own;

    assign own_match = (sig_reg == req_sig) && (pri_reg == req_pri);

    always_comb begin
        tok_next = tok_in;
        idx_next = idx_in;
        take_own = 1'b0;
        // Once a match is found, later slots only pass the token on. Strict
        // less-than keeps the lower index on equal timestamps.
        if (!tok_in.found) begin
            if (own_match) begin
                take_own       = 1'b1;
                tok_next.found = 1'b1;
            end else if (!tok_in.have || (seen_reg < tok_in.seen)) begin
                take_own = 1'b1;
            end
        end
        if (take_own) begin
            tok_next.have   = 1'b1;
            tok_next.cnt    = cnt_reg;
            tok_next.seen   = seen_reg;
            tok_next.anchor = anchor_reg;
            tok_next.sig    = sig_reg;
            tok_next.pri    = pri_reg;
            idx_next        = MY_IDX;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg <= '0;
            idx_reg <= '0;
        end else begin
            tok_reg <= tok_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sig_reg    <= '0;
            pri_reg    <= '0;
            cnt_reg    <= '0;
            seen_reg   <= '0;
            anchor_reg <= '0;
        end else if (wr.en && (wr_idx == MY_IDX)) begin
            sig_reg  <= wr.sig;
            pri_reg  <= wr.pri;
            cnt_reg  <= wr.cnt;
            seen_reg <= wr.seen;
            if (wr.set_anchor) begin
                anchor_reg <= wr.seen;
            end
        end
    end

    assign tok_out = tok_reg;
    assign idx_out = idx_reg;

endmodule

// ===== rtl/log_repeat_suppression_table.sv =====
// Top level of the log repeat suppression table: control sequencer, chain of
// slot cells and result register. Depends on lrst_pkg, lrst_cell, assert_macros.svh.
//
// Each accepted event is checked against the severity levels and then looked up
// in a table of SLOTS recent messages. The lookup is a token that walks the row
// of slot cells one cell per cycle; a dropped event skips the lookup. One event
// is in work at a time; s_tready returns high in the cycle after the previous
// event has placed its last result in the output register. Each event yields
// one result, or two when an evicted or replaced message had a pending repeat
// count: the repeat report comes first, then the display. Configuration
// registers may be written only while no event is in work.
`include "assert_macros.svh"

module log_repeat_suppression_table #(
    parameter int SLOTS = lrst_pkg::SLOTS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Input events.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [31:0] message_sig, [39:32] priority_req, [103:40] now_us
    input  logic [lrst_pkg::IN_DATA_W-1:0]     s_tdata,
    // Results.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [2:0] slot, [34:3] rep_sig, [42:35] rep_priority, [58:43] repeat_count,
    // [122:59] stamp_us, [123] to_host, upper bits zero
    output logic [lrst_pkg::OUT_DATA_W-1:0]    m_tdata,
    // [1:0] action
    output logic [lrst_pkg::ACT_W-1:0]         m_tuser,
    output logic                               m_tlast,
    // Configuration writes.
    input  logic                               cfg_we,
    input  logic [lrst_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [lrst_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import lrst_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);

    // Configuration.
    logic [LVL_W-1:0]   console_reg;
    logic [LVL_W-1:0]   host_reg;
    logic [DEDUP_W-1:0] dedup_reg;
    logic [WIN_W-1:0]   window_reg;

    // Current event.
    logic [SIG_W-1:0]  req_sig_reg;
    logic [PRI_W-1:0]  req_pri_reg;
    logic [TIME_W-1:0] req_now_reg;

    // Lookup result.
    logic [IDX_W-1:0]  res_idx_reg;
    logic [CNT_W-1:0]  res_cnt_reg;
    logic [TIME_W-1:0] res_seen_reg;
    logic [SIG_W-1:0]  res_sig_reg;
    logic [PRI_W-1:0]  res_pri_reg;

    state_t state_reg, state_next;
    logic   start_reg, start_next;

    // Result register.
    logic                  m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    action_t               m_tuser_reg;
    logic                  m_tlast_reg;

    logic                  in_accept;
    logic                  out_free;
    logic                  drop_lvl;
    logic                  host_ok;
    logic                  hit;
    logic [TIME_W-1:0]     age;
    logic                  capture;

    logic                  emit;
    action_t               emit_act;
    logic [IDX_W-1:0]      emit_idx;
    logic [SIG_W-1:0]      emit_sig;
    logic [PRI_W-1:0]      emit_pri;
    logic [CNT_W-1:0]      emit_cnt;
    logic [TIME_W-1:0]     emit_stamp;
    logic                  emit_host;
    logic                  emit_last;

    slot_wr_t              wr;

    scan_t                 tok   [SLOTS+1];
    logic [IDX_W-1:0]      idx_c [SLOTS+1];
    logic [SLOTS-1:0]      tok_valid;

    // ------------------------------------------------------------------
    // Configuration port and window length.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            console_reg <= LVL_W'(7);
            host_reg    <= LVL_W'(7);
            dedup_reg   <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_CONSOLE: console_reg <= cfg_wdata[LVL_W-1:0];
                REG_HOST:    host_reg    <= cfg_wdata[LVL_W-1:0];
                REG_DEDUP:   dedup_reg   <= cfg_wdata[DEDUP_W-1:0];
                default:     ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        window_reg <= WIN_W'(dedup_reg) * WIN_W'(US_PER_SECOND);
    end

    // ------------------------------------------------------------------
    // Chain of slot cells.
    assign tok[0]   = '{valid: start_reg, found: 1'b0, have: 1'b0, cnt: '0,
                        seen: '0, anchor: '0, sig: '0, pri: '0};
    assign idx_c[0] = '0;

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        lrst_cell #(
            .IDX_W    (IDX_W),
            .CELL_IDX (g)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .req_sig (req_sig_reg),
            .req_pri (req_pri_reg),
            .tok_in  (tok[g]),
            .idx_in  (idx_c[g]),
            .tok_out (tok[g+1]),
            .idx_out (idx_c[g+1]),
            .wr      (wr),
            .wr_idx  (res_idx_reg)
        );
        assign tok_valid[g] = tok[g+1].valid;
    end

    // ------------------------------------------------------------------
    // Sequencer.
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign drop_lvl  = s_tdata[SIG_W +: LVL_W] > console_reg;
    assign host_ok   = req_pri_reg[LVL_W-1:0] <= host_reg;
    assign age       = req_now_reg - tok[SLOTS].anchor;
    assign hit       = tok[SLOTS].found && (age < TIME_W'(window_reg));
    assign s_tready  = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        start_next = 1'b0;
        capture    = 1'b0;
        emit       = 1'b0;
        emit_act   = ACT_DROP;
        emit_idx   = res_idx_reg;
        emit_sig   = req_sig_reg;
        emit_pri   = req_pri_reg;
        emit_cnt   = '0;
        emit_stamp = req_now_reg;
        emit_host  = host_ok;
        emit_last  = 1'b1;
        wr         = '{en: 1'b0, set_anchor: 1'b0, sig: req_sig_reg,
                       pri: req_pri_reg, cnt: '0, seen: req_now_reg};
        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    if (drop_lvl) begin
                        state_next = ST_DROP;
                    end else begin
                        state_next = ST_SEARCH;
                        start_next = 1'b1;
                    end
                end
            end
            ST_DROP: begin
                emit_idx   = '0;
                emit_sig   = '0;
                emit_pri   = '0;
                emit_stamp = '0;
                emit_host  = 1'b0;
                if (out_free) begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SEARCH: begin
                if (tok[SLOTS].valid) begin
                    capture = 1'b1;
                    if (hit) begin
                        state_next = ST_SUPP;
                    end else if (tok[SLOTS].cnt != '0) begin
                        state_next = ST_REPORT;
                    end else begin
                        state_next = ST_DISP;
                    end
                end
            end
            ST_SUPP: begin
                emit_act  = ACT_SUPP;
                emit_cnt  = res_cnt_reg + CNT_W'(1);
                emit_host = 1'b0;
                wr.cnt    = emit_cnt;
                if (out_free) begin
                    emit       = 1'b1;
                    wr.en      = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_REPORT: begin
                emit_act   = ACT_REPORT;
                emit_sig   = res_sig_reg;
                emit_pri   = res_pri_reg;
                emit_cnt   = res_cnt_reg;
                emit_stamp = res_seen_reg;
                emit_last  = 1'b0;
                if (out_free) begin
                    emit       = 1'b1;
                    state_next = ST_DISP;
                end
            end
            ST_DISP: begin
                emit_act      = ACT_DISPLAY;
                wr.set_anchor = 1'b1;
                if (out_free) begin
                    emit       = 1'b1;
                    wr.en      = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            start_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            start_reg <= start_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            req_sig_reg <= s_tdata[SIG_W-1:0];
            req_pri_reg <= s_tdata[SIG_W +: PRI_W];
            req_now_reg <= s_tdata[SIG_W+PRI_W +: TIME_W];
        end
        if (capture) begin
            res_idx_reg  <= idx_c[SLOTS];
            res_cnt_reg  <= tok[SLOTS].cnt;
            res_seen_reg <= tok[SLOTS].seen;
            res_sig_reg  <= tok[SLOTS].sig;
            res_pri_reg  <= tok[SLOTS].pri;
        end
    end

    // ------------------------------------------------------------------
    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_tdata_reg <= {4'b0, emit_host, emit_stamp, emit_cnt, emit_pri,
                            emit_sig, SLOT_W'(emit_idx)};
            m_tuser_reg <= emit_act;
            m_tlast_reg <= emit_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // ------------------------------------------------------------------
    // Assertions.
    `ASSERT_CLK(a_one_token, $countones(tok_valid) <= 1,
        "more than one search token in the slot chain")
    `ASSERT_CLK(a_token_in_search, tok[SLOTS].valid |-> state_reg == ST_SEARCH,
        "search token left the chain outside the search state")
    `ASSERT_NEVER(a_write_in_search, wr.en && (state_reg == ST_SEARCH || start_reg),
        "slot write-back while a search is running")
    `ASSERT_CLK(a_accept_busy, in_accept |=> state_reg != ST_IDLE,
        "accepted transaction did not start work")
    `ASSERT_CLK(a_report_not_last, emit && emit_act == ACT_REPORT |-> !emit_last,
        "repeat report marked as final result")

endmodule
